// ===== hdl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the byte signature displacement scan.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int PATTERN_W   = 64;
  localparam int LENGTH_W    = 4;
  localparam int DISP_W      = 32;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Result queue depth and the width of its fill count.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [PATTERN_W-1:0] RST_PATTERN_BYTES  = '0;
  localparam logic [LENGTH_W-1:0]  RST_PATTERN_LENGTH = 4'd1;
  localparam logic [DISP_W-1:0]    RST_DISP_LOW       = 32'h0000_0000;
  localparam logic [DISP_W-1:0]    RST_DISP_HIGH      = 32'hFFFF_FFFF;
  localparam logic [INDEX_W-1:0]   RST_MATCH_INDEX    = 4'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES  = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_DISP_LOW       = 3'd2,
    REG_DISP_HIGH      = 3'd3,
    REG_MATCH_INDEX    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bytes;
    logic [LENGTH_W-1:0]  pattern_length;
    logic [DISP_W-1:0]    disp_low;
    logic [DISP_W-1:0]    disp_high;
    logic [INDEX_W-1:0]   match_index;
  } cfg_t;

  typedef struct packed {
    logic [DISP_W-1:0] displacement;
    logic              found;
  } result_t;

endpackage

// ===== hdl/byte_signature_displacement_scan_top.sv =====
// The byte that causes a result word is registered in the input stage, and the
// word is then written into the result queue, from which it is offered.
// Throughput: one byte per cycle while in_stall is low. The head compare over the
// byte history shift register is combinational; a three-entry result queue
// absorbs output stalls. Reset is synchronous and active high; it clears the scan
// state and the queue and loads the register reset values.
// ----------------------------------------------------------------------------
// byte_signature_displacement_scan_top
// Scans a byte stream for a head pattern followed by a ranged displacement.
// ----------------------------------------------------------------------------
module byte_signature_displacement_scan_top
  import bsd_pkg::*;
#(
  parameter int WINDOW_BYTES      = 320,
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DISP_W-1:0]      displacement,
  output logic                   found
);

  cfg_t                  cfg;
  logic                  stage_valid;
  logic [7:0]            stage_byte;
  logic                  stage_last;
  logic                  push;
  result_t               push_data;
  result_t               out_data;
  logic [FIFO_CNT_W-1:0] fill;
  logic                  in_accept;

  // Stall whenever the queue could not take a word from every byte in flight.
  assign in_stall  = ({1'b0, fill} + {{FIFO_CNT_W{1'b0}}, stage_valid})
                     >= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes  <= RST_PATTERN_BYTES;
      cfg.pattern_length <= RST_PATTERN_LENGTH;
      cfg.disp_low       <= RST_DISP_LOW;
      cfg.disp_high      <= RST_DISP_HIGH;
      cfg.match_index    <= RST_MATCH_INDEX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  cfg.pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LENGTH_W-1:0];
        REG_DISP_LOW:       cfg.disp_low       <= cfg_data[DISP_W-1:0];
        REG_DISP_HIGH:      cfg.disp_high      <= cfg_data[DISP_W-1:0];
        REG_MATCH_INDEX:    cfg.match_index    <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  bsd_matcher #(
    .WINDOW_BYTES      (WINDOW_BYTES),
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (stage_valid),
    .item_byte  (stage_byte),
    .item_last  (stage_last),
    .push       (push),
    .result     (push_data)
  );

  bsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fill      (fill)
  );

  assign displacement = out_data.displacement;
  assign found        = out_data.found;

endmodule

// ===== hdl/bsd_matcher.sv =====
// ----------------------------------------------------------------------------
// bsd_matcher
// Byte history, window position, match counter and the combinational
// head compare and displacement range check.
// ----------------------------------------------------------------------------
module bsd_matcher
  import bsd_pkg::*;
#(
  parameter int WINDOW_BYTES      = 320,
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          item_valid,
  input  logic [7:0]    item_byte,
  input  logic          item_last,
  output logic          push,
  output result_t       result
);

  localparam int HIST  = MAX_PATTERN_BYTES + 4;
  localparam int POS_W = $clog2(WINDOW_BYTES + 1);

  logic [7:0]         hist [HIST];
  logic [7:0]         hist_next [HIST];
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;
  logic [COUNT_W-1:0] count;
  logic               answered;

  logic [LENGTH_W-1:0]          head_len;
  logic [MAX_PATTERN_BYTES-1:0] hit_vec;
  logic                         hit;
  logic                         active;
  logic                         span_ok;
  logic [DISP_W-1:0]            disp;
  logic                         qualify;
  logic                         report;

  always_comb begin
    head_len = cfg.pattern_length;
    if (head_len == '0) begin
      head_len = LENGTH_W'(1);
    end else if (head_len > LENGTH_W'(MAX_PATTERN_BYTES)) begin
      head_len = LENGTH_W'(MAX_PATTERN_BYTES);
    end
  end

  always_comb begin
    hist_next[0] = item_byte;
    for (int i = 1; i < HIST; i++) begin
      hist_next[i] = hist[i-1];
    end
  end

  // One compare set per possible head length; the head ends just before the
  // four displacement bytes, oldest head byte matching pattern byte 0.
  always_comb begin
    for (int n = 1; n <= MAX_PATTERN_BYTES; n++) begin
      hit_vec[n-1] = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (hist_next[n+3-k] != cfg.pattern_bytes[8*k +: 8]) begin
          hit_vec[n-1] = 1'b0;
        end
      end
    end
    hit = 1'b0;
    for (int n = 1; n <= MAX_PATTERN_BYTES; n++) begin
      if (head_len == LENGTH_W'(n)) begin
        hit = hit_vec[n-1];
      end
    end
  end

  assign active   = !answered && (pos < POS_W'(WINDOW_BYTES));
  assign pos_next = pos + POS_W'(1);
  assign span_ok  = pos_next >= (POS_W'(head_len) + POS_W'(4));
  assign disp     = {hist_next[0], hist_next[1], hist_next[2], hist_next[3]};
  assign qualify  = active && span_ok && hit &&
                    (disp >= cfg.disp_low) && (disp < cfg.disp_high);
  assign report   = qualify && (count == {1'b0, cfg.match_index});

  assign push                = item_valid && (report || (item_last && !answered));
  assign result.displacement = report ? disp : '0;
  assign result.found        = report;

  always_ff @(posedge clk) begin
    if (item_valid && active) begin
      for (int i = 0; i < HIST; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      count    <= '0;
      answered <= 1'b0;
    end else if (item_valid) begin
      if (item_last) begin
        pos      <= '0;
        count    <= '0;
        answered <= 1'b0;
      end else if (active) begin
        pos <= pos_next;
        if (qualify && count != COUNT_MAX) begin
          count <= count + COUNT_W'(1);
        end
        if (report) begin
          answered <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/bsd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bsd_out_fifo
// Small result queue that decouples the scan from the output handshake.
// ----------------------------------------------------------------------------
module bsd_out_fifo
  import bsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  output logic [FIFO_CNT_W-1:0] fill
);

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = fill != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

endmodule
